@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk, skipped while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds whenever a qualifier is set.
`define ASSERT_WHEN(label, qual, prop, msg) \
    `ASSERT_CLK(label, (qual) |-> (prop), msg)

`endif

@@ hdl/fpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes and the beat types of the input and result channels.
// ----------------------------------------------------------------------------
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_INC  = 4'd4,
        OP_DEC  = 4'd5,
        OP_MIN  = 4'd6,
        OP_MAX  = 4'd7,
        OP_ITOF = 4'd8,
        OP_FTOI = 4'd9
    } t_op;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               less_flag;
        logic               equal_flag;
        logic               greater_flag;
        logic               overflow_flag;
        logic               divide_zero_flag;
    } t_out;

endpackage

@@ hdl/fpa_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Three-stage magnitude multiplier: two half-width partial products, sum with
// rounding half, then scale down by the fraction bits and saturate by sign.
// ----------------------------------------------------------------------------
module fpa_mul #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic                 i_neg,
    output logic [WORD_BITS-1:0] o_res,
    output logic                 o_ovf
);
    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int HB = (W + 1) / 2;
    localparam int HH = W - HB;
    localparam int PW = 2 * W;
    localparam int QW = PW - F;
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);
    localparam logic [QW-1:0] QMAX = (QW'(1) << (W - 1)) - QW'(1);
    localparam logic [QW-1:0] QMIN = QW'(1) << (W - 1);
    localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

    logic [W+HB-1:0] r_p0;
    logic [W+HH-1:0] r_p1;
    logic            r_neg1, r_neg2;
    logic [PW-1:0]   r_sum;
    logic [QW-1:0]   n_q;
    logic [W-1:0]    n_res;
    logic            n_ovf;

    // Stage 1: partial products against the low and high halves of b
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= (W+HB)'(i_a) * (W+HB)'(i_b[HB-1:0]);
            r_p1   <= (W+HH)'(i_a) * (W+HH)'(i_b[W-1:HB]);
            r_neg1 <= i_neg;
        end
    end

    // Stage 2: full product plus the rounding half
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= PW'(r_p0) + (PW'(r_p1) << HB) + HALF;
            r_neg2 <= r_neg1;
        end
    end

    // Stage 3: scale down and clamp to the word range
    always_comb begin
        n_q   = r_sum[PW-1:F];
        n_ovf = 1'b0;
        if (r_neg2) begin
            if (n_q > QMIN) begin
                n_ovf = 1'b1;
                n_res = WMIN;
            end else begin
                n_res = ~n_q[W-1:0] + W'(1);
            end
        end else begin
            if (n_q > QMAX) begin
                n_ovf = 1'b1;
                n_res = WMAX;
            end else begin
                n_res = n_q[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
            o_ovf <= n_ovf;
        end
    end

endmodule

@@ hdl/fpa_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per register stage. The dividend is the
// numerator magnitude shifted up by the fraction bits; the round bit is set
// when twice the final remainder reaches the divisor.
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [WORD_BITS-1:0]           i_num,
    input  logic [WORD_BITS-1:0]           i_den,
    output logic [WORD_BITS+FRAC_BITS-1:0] o_quo,
    output logic                           o_rnd
);
    localparam int W  = WORD_BITS;
    localparam int QB = WORD_BITS + FRAC_BITS;

    logic [W-1:0]  r_rem [QB];
    logic [QB-1:0] r_nq  [QB];
    logic [W-1:0]  r_den [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic [W-1:0]  s_rem;
            logic [QB-1:0] s_nq;
            logic [W-1:0]  s_den;
            logic [W:0]    s_sh;
            logic [W:0]    s_dif;
            logic          s_ge;

            // Pick up the previous stage, or the operands at the first one
            if (k == 0) begin : g_first
                assign s_rem = '0;
                assign s_nq  = {i_num, {FRAC_BITS{1'b0}}};
                assign s_den = i_den;
            end else begin : g_next
                assign s_rem = r_rem[k-1];
                assign s_nq  = r_nq[k-1];
                assign s_den = r_den[k-1];
            end

            // Shift in the next dividend bit and try the subtract
            assign s_sh  = {s_rem, s_nq[QB-1]};
            assign s_ge  = s_sh >= {1'b0, s_den};
            assign s_dif = s_sh - {1'b0, s_den};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= s_ge ? s_dif[W-1:0] : s_sh[W-1:0];
                    r_nq[k]  <= {s_nq[QB-2:0], s_ge};
                    r_den[k] <= s_den;
                end
            end
        end
    endgenerate

    assign o_quo = r_nq[QB-1];
    assign o_rnd = {r_rem[QB-1], 1'b0} >= {1'b0, r_den[QB-1]};

endmodule

@@ hdl/fixed_point_alu_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed fixed-point add, subtract, multiply, divide, step, min/max and
// integer conversions with compare, overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one operation beat (op and two
//   raw operands); result channel o_valid / i_stall carries one result beat.
//   A beat moves on a rising edge with valid high and stall low.
//   Every operation runs through the same pipeline: an input register, one
//   divider stage per quotient bit (WORD_BITS + FRAC_BITS of them), and the
//   output register. While o_stall is low, one beat enters per cycle. The
//   multiplier runs three stages in parallel and is delayed to match.
//   When the receiver stalls while a result is held, the whole pipeline
//   freezes and o_stall rises in the same cycle; nothing is dropped.
//   Reset clears all valid bits; the block takes a beat right after reset.
//   Results for codes beyond fixed_to_int are zero with flags from compare.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  fpa_pkg::t_in i_in,
    output logic         o_valid,
    input  logic         i_stall,
    output fpa_pkg::t_out o_out
);
    import fpa_pkg::*;

    `include "assert_macros.svh"

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int QB  = W + F;
    localparam int SW  = W + F + 1;
    localparam int EXT = (W > 32) ? W : 32;
    localparam int MD  = QB - 3;
    localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0] SMAX = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic [SW-1:0] SMIN = SW'(1) << (W - 1);

    // Sign-extend a 32-bit operand, then keep the word's bits
    function automatic logic [W-1:0] f_take(input logic signed [31:0] v);
        logic [EXT-1:0] x;
        x = EXT'(v);
        return x[W-1:0];
    endfunction

    // Low 32 bits of a word, zero-filled for narrow words
    function automatic logic [31:0] f_low(input logic [W-1:0] v);
        logic [EXT-1:0] x;
        x = EXT'(v);
        return x[31:0];
    endfunction

    // Build a word from sign and magnitude; top bit of the return is overflow
    function automatic logic [W:0] f_sat(input logic neg, input logic [SW-1:0] m);
        logic [SW-1:0] nm;
        nm = ~m + SW'(1);
        if (neg) begin
            if (m > SMIN) return {1'b1, WMIN};
            return {1'b0, nm[W-1:0]};
        end
        if (m > SMAX) return {1'b1, WMAX};
        return {1'b0, m[W-1:0]};
    endfunction

    logic         en;
    logic         r_s1_vld;
    logic [3:0]   r_s1_op;
    logic [W-1:0] r_s1_a, r_s1_b;

    logic [W-1:0] mag_a, mag_b, sum, dif, incv, decv;
    logic         lt, eq, gt, a_neg, p_neg, b_zero;
    logic [W-1:0] s_res;
    logic         s_ovf;
    logic [W:0]   itof_sat;

    logic         r_vld   [QB];
    logic [3:0]   r_d_op  [QB];
    logic [2:0]   r_d_cmp [QB];
    logic [W-1:0] r_d_res [QB];
    logic         r_d_ovf [QB];
    logic         r_d_neg [QB];
    logic         r_d_bz  [QB];
    logic         r_d_an  [QB];

    logic [W-1:0] mul_res;
    logic         mul_ovf;
    logic [W-1:0] r_m_res [MD];
    logic         r_m_ovf [MD];

    logic [QB-1:0] div_quo;
    logic          div_rnd;
    logic [W:0]    div_sat;

    logic         n_res_ovf;
    logic [W-1:0] n_res;
    logic         n_dz;

    logic         r_o_vld;
    logic [31:0]  r_o_res;
    logic [2:0]   r_o_cmp;
    logic         r_o_ovf;
    logic         r_o_dz;

    // Advance the pipeline unless a held result is stalled
    assign en      = !(r_o_vld && i_stall);
    assign o_stall = !en;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op <= i_in.op;
            r_s1_a  <= f_take(i_in.operand_a);
            r_s1_b  <= f_take(i_in.operand_b);
        end
    end

    // Compare, magnitudes and the operations done without the multiplier or divider
    assign lt     = $signed(r_s1_a) < $signed(r_s1_b);
    assign eq     = r_s1_a == r_s1_b;
    assign gt     = $signed(r_s1_a) > $signed(r_s1_b);
    assign a_neg  = r_s1_a[W-1];
    assign p_neg  = r_s1_a[W-1] ^ r_s1_b[W-1];
    assign b_zero = r_s1_b == '0;
    assign mag_a  = a_neg ? (~r_s1_a + W'(1)) : r_s1_a;
    assign mag_b  = r_s1_b[W-1] ? (~r_s1_b + W'(1)) : r_s1_b;
    assign sum    = r_s1_a + r_s1_b;
    assign dif    = r_s1_a - r_s1_b;
    assign incv   = r_s1_a + W'(1);
    assign decv   = r_s1_a - W'(1);
    assign itof_sat = f_sat(a_neg, SW'(mag_a) << F);

    always_comb begin
        s_res = '0;
        s_ovf = 1'b0;
        case (t_op'(r_s1_op))
            OP_ADD: begin
                s_res = sum;
                s_ovf = !(r_s1_a[W-1] ^ r_s1_b[W-1]) && (sum[W-1] ^ r_s1_a[W-1]);
            end
            OP_SUB: begin
                s_res = dif;
                s_ovf = (r_s1_a[W-1] ^ r_s1_b[W-1]) && (dif[W-1] ^ r_s1_a[W-1]);
            end
            OP_INC: begin
                s_res = incv;
                s_ovf = r_s1_a == WMAX;
            end
            OP_DEC: begin
                s_res = decv;
                s_ovf = r_s1_a == WMIN;
            end
            OP_MIN:  s_res = gt ? r_s1_b : r_s1_a;
            OP_MAX:  s_res = gt ? r_s1_a : r_s1_b;
            OP_ITOF: begin
                s_res = itof_sat[W-1:0];
                s_ovf = itof_sat[W];
            end
            OP_FTOI: s_res = W'($signed(r_s1_a) >>> F);
            OP_MUL, OP_DIV: begin
                s_res = '0;
                s_ovf = 1'b0;
            end
            default: begin
                s_res = '0;
                s_ovf = 1'b0;
            end
        endcase
    end

    // Carry valid bits down the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QB; j++) r_vld[j] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r_s1_vld;
            for (int j = 1; j < QB; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    // Delay the side results alongside the divider
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_op[0]  <= r_s1_op;
            r_d_cmp[0] <= {lt, eq, gt};
            r_d_res[0] <= s_res;
            r_d_ovf[0] <= s_ovf;
            r_d_neg[0] <= p_neg;
            r_d_bz[0]  <= b_zero;
            r_d_an[0]  <= a_neg;
            for (int j = 1; j < QB; j++) begin
                r_d_op[j]  <= r_d_op[j-1];
                r_d_cmp[j] <= r_d_cmp[j-1];
                r_d_res[j] <= r_d_res[j-1];
                r_d_ovf[j] <= r_d_ovf[j-1];
                r_d_neg[j] <= r_d_neg[j-1];
                r_d_bz[j]  <= r_d_bz[j-1];
                r_d_an[j]  <= r_d_an[j-1];
            end
        end
    end

    fpa_mul #(
        .WORD_BITS (W),
        .FRAC_BITS (F)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (mag_a),
        .i_b   (mag_b),
        .i_neg (p_neg),
        .o_res (mul_res),
        .o_ovf (mul_ovf)
    );

    // Delay the product to line up with the quotient
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_res[0] <= mul_res;
            r_m_ovf[0] <= mul_ovf;
            for (int j = 1; j < MD; j++) begin
                r_m_res[j] <= r_m_res[j-1];
                r_m_ovf[j] <= r_m_ovf[j-1];
            end
        end
    end

    fpa_div #(
        .WORD_BITS (W),
        .FRAC_BITS (F)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (mag_a),
        .i_den (mag_b),
        .o_quo (div_quo),
        .o_rnd (div_rnd)
    );

    // Round and clamp the quotient, then select the result
    assign div_sat = f_sat(r_d_neg[QB-1], SW'(div_quo) + SW'(div_rnd));

    always_comb begin
        n_res     = r_d_res[QB-1];
        n_res_ovf = r_d_ovf[QB-1];
        n_dz      = 1'b0;
        case (t_op'(r_d_op[QB-1]))
            OP_MUL: begin
                n_res     = r_m_res[MD-1];
                n_res_ovf = r_m_ovf[MD-1];
            end
            OP_DIV: begin
                if (r_d_bz[QB-1]) begin
                    n_res     = r_d_an[QB-1] ? WMIN : WMAX;
                    n_res_ovf = 1'b0;
                    n_dz      = 1'b1;
                end else begin
                    n_res     = div_sat[W-1:0];
                    n_res_ovf = div_sat[W];
                end
            end
            default: begin
                n_res     = r_d_res[QB-1];
                n_res_ovf = r_d_ovf[QB-1];
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_vld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res <= f_low(n_res);
            r_o_cmp <= r_d_cmp[QB-1];
            r_o_ovf <= n_res_ovf;
            r_o_dz  <= n_dz;
        end
    end

    assign o_valid                = r_o_vld;
    assign o_out.result_value     = r_o_res;
    assign o_out.less_flag        = r_o_cmp[2];
    assign o_out.equal_flag       = r_o_cmp[1];
    assign o_out.greater_flag     = r_o_cmp[0];
    assign o_out.overflow_flag    = r_o_ovf;
    assign o_out.divide_zero_flag = r_o_dz;

    // Exactly one compare outcome per result beat
    `ASSERT_WHEN(a_cmp_onehot, o_valid,
        $onehot({o_out.less_flag, o_out.equal_flag, o_out.greater_flag}),
        "compare flags not one-hot")

    // A divide by zero never also reports overflow
    `ASSERT_WHEN(a_dz_no_ovf, o_valid,
        !(o_out.divide_zero_flag && o_out.overflow_flag),
        "divide-by-zero beat flags overflow")

    // An accepted beat lands in the input register
    `ASSERT_CLK(a_accept_lands, (i_valid && !o_stall) |=> r_s1_vld,
        "accepted beat lost at input register")

endmodule
